[hw/rtl/multilevel_run_queue_scheduler_assert.svh]
// Assertion macros for the multilevel run queue scheduler.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef MULTILEVEL_RUN_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_RUN_QUEUE_SCHEDULER_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define MRQS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// implication: cons holds in the same cycle as ante
`define MRQS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/mrqs_pkg.sv]
// Shared types and constants of the multilevel run queue scheduler.
// No dependencies.
`default_nettype none
package mrqs_pkg;

  localparam int QUEUES      = 3;
  localparam int QUEUE_DEPTH = 16;
  localparam int QW          = 2;   // queue field width
  localparam int IW          = 4;   // index field width
  localparam int CW          = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS       = QUEUES * QUEUE_DEPTH;
  localparam int AW          = $clog2(SLOTS);

  localparam int PRIO_LIMIT  = 140;
  localparam int PRIO_SPLIT  = 120;
  localparam int SCALE_HI    = 20;
  localparam int SCALE_LO    = 5;
  localparam int BASE_W      = 12;  // (140-p)*20 fits in 12 bits
  localparam int PROD_W      = BASE_W + 8;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_SELECT = 3'd1,
    OP_DELETE = 3'd2,
    OP_MOVE   = 3'd3,
    OP_ADD    = 3'd4,
    OP_MARK   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_NONE      = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [7:0]  prio;
    logic [1:0]  cls;
    logic [15:0] rem;
    logic        started;
    logic [31:0] turn;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic chk;
    logic walk;
    logic eval;
    logic ent_rd;
    logic ent_ex;
    logic sh;
    logic sh_wr;
    logic q1;
    logic q2;
    logic q3;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic err;
    logic walk_has;
    logic found;
    logic last_q;
    logic sh_more;
  } stat_t;

  function automatic logic [AW-1:0] slot_addr(input logic [QW-1:0] q,
                                              input logic [IW-1:0] i);
    return AW'(q) * AW'(QUEUE_DEPTH) + AW'(i);
  endfunction

endpackage
`default_nettype wire

[hw/rtl/mrqs_datapath.sv]
// Datapath: entry memory, queue counts, walk pointers, quantum and result words.
// Depends on mrqs_pkg and the assertion header.
`default_nettype none
`include "multilevel_run_queue_scheduler_assert.svh"
module mrqs_datapath import mrqs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output stat_t            stat_o,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [1:0]  queue_sel_i,
  input  wire logic [1:0]  dest_queue_i,
  input  wire logic [3:0]  entry_index_i,
  input  wire logic [7:0]  task_id_i,
  input  wire logic [7:0]  task_priority_i,
  input  wire logic [1:0]  sched_class_i,
  input  wire logic [15:0] remaining_time_i,
  input  wire logic        started_flag_i,
  input  wire logic [15:0] time_slice_i,
  output logic [1:0]       status_o,
  output logic [1:0]       result_queue_o,
  output logic [3:0]       result_index_o,
  output logic [7:0]       result_task_o,
  output logic [7:0]       result_priority_o,
  output logic [1:0]       result_class_o,
  output logic [15:0]      quantum_o,
  output logic [31:0]      result_turnaround_o
);

  // captured word
  op_e           op_q;
  logic [QW-1:0] qs_q, qd_q;
  logic [IW-1:0] idx_q;
  entry_t        in_q;
  logic [15:0]   slice_q;

  // control state
  logic [CW-1:0] cnt_q [QUEUES];
  logic [7:0]    mult_q;
  logic [QW-1:0] ptr_q_q;
  logic [CW-1:0] ptr_i_q;
  logic [CW-1:0] sh_i_q;
  logic          found_q;

  // select working registers
  logic [7:0]    best_q;
  logic [IW-1:0] bi_q;
  entry_t        sel_q;
  logic [BASE_W-1:0] base_q;
  logic [PROD_W-1:0] prod_q;

  // results
  status_e     res_status_q;
  logic [1:0]  res_queue_q;
  logic [3:0]  res_index_q;
  logic [7:0]  res_task_q, res_pri_q;
  logic [1:0]  res_class_q;
  logic [15:0] res_quantum_q;
  logic [31:0] res_turn_q;

  // memory
  entry_t        mem [SLOTS];
  entry_t        rdata_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata;

  function automatic logic [CW-1:0] cnt_of(input logic [CW-1:0] c [QUEUES],
                                           input logic [QW-1:0] q);
    logic [CW-1:0] r;
    r = '0;
    if (int'(q) < QUEUES) r = c[q];
    return r;
  endfunction

  logic [CW-1:0] cnt_qs, cnt_qd, cnt_ptr;
  logic          qs_ok, qd_ok, idx_ok;
  logic [32:0]   turn_sum;
  logic [7:0]    prio_diff;

  assign cnt_qs  = cnt_of(cnt_q, qs_q);
  assign cnt_qd  = cnt_of(cnt_q, qd_q);
  assign cnt_ptr = cnt_of(cnt_q, ptr_q_q);
  assign qs_ok   = int'(qs_q) < QUEUES;
  assign qd_ok   = int'(qd_q) < QUEUES;
  assign idx_ok  = CW'(idx_q) < cnt_qs;
  assign turn_sum  = {1'b0, rdata_q.turn} + 33'(slice_q);
  assign prio_diff = 8'(PRIO_LIMIT) - sel_q.prio;

  // status to controller
  always_comb begin
    stat_o.op       = op_q;
    stat_o.walk_has = ptr_i_q < cnt_ptr;
    stat_o.found    = found_q;
    stat_o.last_q   = int'(ptr_q_q) == QUEUES - 1;
    stat_o.sh_more  = sh_i_q < cnt_qs;
    case (op_q)
      OP_DELETE, OP_MARK: stat_o.err = !qs_ok || !idx_ok;
      OP_MOVE:            stat_o.err = !qs_ok || !qd_ok || !idx_ok ||
                                       (cnt_qd >= CW'(QUEUE_DEPTH));
      default:            stat_o.err = 1'b0;
    endcase
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata_q;
    raddr = slot_addr(ptr_q_q, ptr_i_q[IW-1:0]);
    if (cmd_i.ent_rd) raddr = slot_addr(qs_q, idx_q);
    if (cmd_i.sh)     raddr = slot_addr(qs_q, sh_i_q[IW-1:0]);
    if (cmd_i.chk && op_q == OP_INSERT && qs_ok && cnt_qs < CW'(QUEUE_DEPTH)) begin
      we    = 1'b1;
      waddr = slot_addr(qs_q, cnt_qs[IW-1:0]);
      wdata = in_q;
    end
    if (cmd_i.eval && op_q == OP_ADD && rdata_q.started) begin
      we    = 1'b1;
      waddr = slot_addr(ptr_q_q, ptr_i_q[IW-1:0]);
      wdata.turn = turn_sum[32] ? '1 : turn_sum[31:0];
    end
    if (cmd_i.ent_ex && op_q == OP_MARK) begin
      we    = 1'b1;
      waddr = slot_addr(qs_q, idx_q);
      wdata.started = 1'b1;
    end
    if (cmd_i.ent_ex && op_q == OP_MOVE) begin
      we    = 1'b1;
      waddr = slot_addr(qd_q, cnt_qd[IW-1:0]);
    end
    if (cmd_i.sh_wr) begin
      we    = 1'b1;
      waddr = slot_addr(qs_q, IW'(sh_i_q - CW'(1)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < QUEUES; q++) cnt_q[q] <= '0;
      mult_q  <= 8'd1;
      ptr_q_q <= '0;
      ptr_i_q <= '0;
      sh_i_q  <= '0;
      found_q <= 1'b0;
    end else begin
      if (cfg_we_i) mult_q <= cfg_data_i;
      if (cmd_i.load) begin
        ptr_q_q <= '0;
        ptr_i_q <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.chk && op_q == OP_INSERT && qs_ok && cnt_qs < CW'(QUEUE_DEPTH))
        cnt_q[qs_q] <= cnt_qs + CW'(1);
      if (cmd_i.walk && !stat_o.walk_has && !stat_o.last_q &&
          !(op_q == OP_SELECT && found_q)) begin
        ptr_q_q <= ptr_q_q + QW'(1);
        ptr_i_q <= '0;
      end
      if (cmd_i.eval) begin
        ptr_i_q <= ptr_i_q + CW'(1);
        if (op_q == OP_SELECT && rdata_q.prio < (found_q ? best_q : 8'(PRIO_LIMIT)))
          found_q <= 1'b1;
      end
      if (cmd_i.ent_ex) begin
        sh_i_q <= CW'(idx_q) + CW'(1);
        if (op_q == OP_MOVE) cnt_q[qd_q] <= cnt_qd + CW'(1);
      end
      if (cmd_i.sh && !stat_o.sh_more) cnt_q[qs_q] <= cnt_qs - CW'(1);
      if (cmd_i.sh_wr) sh_i_q <= sh_i_q + CW'(1);
    end
  end

  // payload and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q            <= op_e'(opcode_i);
      qs_q            <= queue_sel_i;
      qd_q            <= dest_queue_i;
      idx_q           <= entry_index_i;
      in_q.task_id    <= task_id_i;
      in_q.prio       <= task_priority_i;
      in_q.cls        <= sched_class_i;
      in_q.rem        <= remaining_time_i;
      in_q.started    <= started_flag_i;
      in_q.turn       <= '0;
      slice_q         <= time_slice_i;
      res_status_q    <= ST_OK;
      res_queue_q     <= '0;
      res_index_q     <= '0;
      res_task_q      <= '0;
      res_pri_q       <= '0;
      res_class_q     <= '0;
      res_quantum_q   <= '0;
      res_turn_q      <= '0;
    end
    // insert and the index checks
    if (cmd_i.chk) begin
      if (op_q == OP_INSERT) begin
        if (!qs_ok) res_status_q <= ST_BAD_INDEX;
        else if (cnt_qs >= CW'(QUEUE_DEPTH)) res_status_q <= ST_FULL;
        else begin
          res_queue_q <= qs_q;
          res_index_q <= cnt_qs[IW-1:0];
          res_task_q  <= in_q.task_id;
          res_pri_q   <= in_q.prio;
          res_class_q <= in_q.cls;
        end
      end else if (stat_o.err) begin
        res_status_q <= (op_q == OP_MOVE && qs_ok && qd_ok && idx_ok) ?
                        ST_FULL : ST_BAD_INDEX;
      end
    end
    // walk end with nothing selectable
    if (cmd_i.walk && !stat_o.walk_has && stat_o.last_q &&
        op_q == OP_SELECT && !found_q)
      res_status_q <= ST_NONE;
    // lowest priority so far
    if (cmd_i.eval && op_q == OP_SELECT &&
        rdata_q.prio < (found_q ? best_q : 8'(PRIO_LIMIT))) begin
      best_q <= rdata_q.prio;
      bi_q   <= ptr_i_q[IW-1:0];
      sel_q  <= rdata_q;
    end
    // single entry report
    if (cmd_i.ent_ex) begin
      res_task_q  <= rdata_q.task_id;
      res_pri_q   <= rdata_q.prio;
      res_class_q <= rdata_q.cls;
      res_turn_q  <= rdata_q.turn;
      if (op_q == OP_MOVE) begin
        res_queue_q <= qd_q;
        res_index_q <= (qs_q == qd_q) ? IW'(cnt_qd - CW'(1)) : cnt_qd[IW-1:0];
      end else begin
        res_queue_q <= qs_q;
        res_index_q <= idx_q;
      end
    end
    // quantum: scale, multiply, clamp
    if (cmd_i.q1) begin
      base_q <= (sel_q.prio < 8'(PRIO_SPLIT)) ?
                BASE_W'(prio_diff) * BASE_W'(SCALE_HI) :
                BASE_W'(prio_diff) * BASE_W'(SCALE_LO);
      res_queue_q <= ptr_q_q;
      res_index_q <= bi_q;
      res_task_q  <= sel_q.task_id;
      res_pri_q   <= sel_q.prio;
      res_class_q <= sel_q.cls;
      res_turn_q  <= sel_q.turn;
    end
    if (cmd_i.q2) prod_q <= PROD_W'(base_q) * PROD_W'(mult_q);
    if (cmd_i.q3) begin
      if (sel_q.cls == 2'd0 || prod_q > PROD_W'(sel_q.rem)) res_quantum_q <= sel_q.rem;
      else res_quantum_q <= prod_q[15:0];
    end
  end

  assign status_o            = res_status_q;
  assign result_queue_o      = res_queue_q;
  assign result_index_o      = res_index_q;
  assign result_task_o       = res_task_q;
  assign result_priority_o   = res_pri_q;
  assign result_class_o      = res_class_q;
  assign quantum_o           = res_quantum_q;
  assign result_turnaround_o = res_turn_q;

  `MRQS_ASSERT(a_ptr_in_range, ptr_i_q <= CW'(QUEUE_DEPTH))
  `MRQS_ASSERT(a_shift_in_range, sh_i_q <= CW'(QUEUE_DEPTH) + CW'(1))
  `MRQS_ASSERT_IMP(a_quantum_has_pick, cmd_i.q1 || cmd_i.q2 || cmd_i.q3, found_q)

endmodule
`default_nettype wire

[hw/rtl/mrqs_ctrl.sv]
// Controller state machine: sequences each operation over the datapath.
// Depends on mrqs_pkg.
`default_nettype none
module mrqs_ctrl import mrqs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CHECK  = 11'b00000000010,
    S_WALK   = 11'b00000000100,
    S_EVAL   = 11'b00000001000,
    S_ENT_RD = 11'b00000010000,
    S_ENT_EX = 11'b00000100000,
    S_SH     = 11'b00001000000,
    S_SH_WR  = 11'b00010000000,
    S_Q1     = 11'b00100000000,
    S_Q2     = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   q3_q;   // clamp step rides on the first cycle of done

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_CHECK;
      S_CHECK: begin
        case (stat_i.op)
          OP_SELECT, OP_ADD: state_d = S_WALK;
          OP_DELETE, OP_MARK, OP_MOVE: state_d = stat_i.err ? S_DONE : S_ENT_RD;
          default: state_d = S_DONE;
        endcase
      end
      S_WALK: begin
        if (stat_i.walk_has) state_d = S_EVAL;
        else if (stat_i.op == OP_SELECT && stat_i.found) state_d = S_Q1;
        else if (stat_i.last_q) state_d = S_DONE;
      end
      S_EVAL:   state_d = S_WALK;
      S_ENT_RD: state_d = S_ENT_EX;
      S_ENT_EX: state_d = (stat_i.op == OP_MARK) ? S_DONE : S_SH;
      S_SH:     state_d = stat_i.sh_more ? S_SH_WR : S_DONE;
      S_SH_WR:  state_d = S_SH;
      S_Q1:     state_d = S_Q2;
      S_Q2:     state_d = S_DONE;
      S_DONE:   if (out_ready_i && !q3_q) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      q3_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      q3_q    <= (state_q == S_Q2);
    end
  end

  // commands
  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_DONE) && !q3_q;
  assign cmd_o.load   = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.chk    = (state_q == S_CHECK);
  assign cmd_o.walk   = (state_q == S_WALK);
  assign cmd_o.eval   = (state_q == S_EVAL);
  assign cmd_o.ent_rd = (state_q == S_ENT_RD);
  assign cmd_o.ent_ex = (state_q == S_ENT_EX);
  assign cmd_o.sh     = (state_q == S_SH);
  assign cmd_o.sh_wr  = (state_q == S_SH_WR);
  assign cmd_o.q1     = (state_q == S_Q1);
  assign cmd_o.q2     = (state_q == S_Q2);
  assign cmd_o.q3     = q3_q;

endmodule
`default_nettype wire

[hw/rtl/multilevel_run_queue_scheduler.sv]
// Steps: insert and error cases finish after the check; mark_started reads and
// rewrites one entry; select walks the queues in order and stops after the first
// queue holding a candidate, then computes the quantum; delete/move shift the
// later entries of the source queue; add_time visits every stored entry.
// One word at a time: a new word is taken after the result is delivered.
// Reset: asynchronous active low, all queues empty, multiplier 1, no clear pass.
`default_nettype none
module multilevel_run_queue_scheduler import mrqs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [1:0]  queue_sel_i,
  input  wire logic [1:0]  dest_queue_i,
  input  wire logic [3:0]  entry_index_i,
  input  wire logic [7:0]  task_id_i,
  input  wire logic [7:0]  task_priority_i,
  input  wire logic [1:0]  sched_class_i,
  input  wire logic [15:0] remaining_time_i,
  input  wire logic        started_flag_i,
  input  wire logic [15:0] time_slice_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [1:0]       result_queue_o,
  output logic [3:0]       result_index_o,
  output logic [7:0]       result_task_o,
  output logic [7:0]       result_priority_o,
  output logic [1:0]       result_class_o,
  output logic [15:0]      quantum_o,
  output logic [31:0]      result_turnaround_o
);

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_we;

  // configuration is only written while idle
  assign cfg_ready_o = in_ready_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  mrqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mrqs_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_we_i            (cfg_we),
    .cfg_data_i          (cfg_data_i),
    .opcode_i            (opcode_i),
    .queue_sel_i         (queue_sel_i),
    .dest_queue_i        (dest_queue_i),
    .entry_index_i       (entry_index_i),
    .task_id_i           (task_id_i),
    .task_priority_i     (task_priority_i),
    .sched_class_i       (sched_class_i),
    .remaining_time_i    (remaining_time_i),
    .started_flag_i      (started_flag_i),
    .time_slice_i        (time_slice_i),
    .status_o            (status_o),
    .result_queue_o      (result_queue_o),
    .result_index_o      (result_index_o),
    .result_task_o       (result_task_o),
    .result_priority_o   (result_priority_o),
    .result_class_o      (result_class_o),
    .quantum_o           (quantum_o),
    .result_turnaround_o (result_turnaround_o)
  );

endmodule
`default_nettype wire
